// File: rtl/averaged_hysteresis_thermostat_macros.svh
// Assertion helpers shared by the thermostat RTL.
// All of them sample on the rising edge of clock and are off during reset.
`ifndef AVERAGED_HYSTERESIS_THERMOSTAT_MACROS_SVH
`define AVERAGED_HYSTERESIS_THERMOSTAT_MACROS_SVH

// cond must hold on every edge
`define AHT_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// ante implies cons on the same edge
`define AHT_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// ante implies cons on the following edge
`define AHT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/aht_pkg.sv
package aht_pkg;

   // averaging window
   localparam int WINDOW = 10;

   // field widths
   localparam int SAMPLE_W   = 10;
   localparam int SETPOINT_W = 7;
   localparam int SINT_W     = 8;
   localparam int BINT_W     = 10;
   localparam int AVG_W      = 8;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 10;

   localparam int IDX_W      = $clog2(WINDOW);
   localparam int SAMPLE_MAX = 1023;
   localparam int SUM_MAX    = WINDOW * SAMPLE_MAX;
   localparam int SUM_W      = $clog2(SUM_MAX + 1);

   // avg = floor(sum * SCALE / DIVISOR), done as a reciprocal multiply plus one
   // correction step; 2^RECIP_SH exceeds the largest dividend for this window
   localparam int SCALE    = 500;
   localparam int DIVISOR  = SAMPLE_MAX * WINDOW;
   localparam int X_MAX    = SUM_MAX * SCALE;
   localparam int X_W      = $clog2(X_MAX + 1);
   localparam int RECIP_SH = 24;
   localparam int RECIP    = (1 << RECIP_SH) / DIVISOR;
   localparam int QM       = SCALE * RECIP;
   localparam int QM_W     = $clog2(QM + 1);
   localparam int PROD_W   = SUM_W + QM_W;
   localparam int Q_MAX    = X_MAX / DIVISOR;
   localparam int Q_W      = $clog2(Q_MAX + 2);
   localparam int AVG_MAX  = 255;

   // hysteresis margins in degrees
   localparam int HEAT_ON_MARGIN  = 5;
   localparam int HEAT_OFF_MARGIN = 4;
   localparam int FAN_MARGIN      = 5;

   // register reset values
   localparam logic [SETPOINT_W-1:0] SETPOINT_RST = SETPOINT_W'(60);
   localparam logic [SINT_W-1:0]     SINT_RST     = SINT_W'(10);
   localparam logic [BINT_W-1:0]     BINT_RST     = BINT_W'(100);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SETPOINT   = 2'd0,
      CSR_SAMPLE_INT = 2'd1,
      CSR_BLINK_INT  = 2'd2
   } csr_index_type;

   // per-beat control that travels down the pipeline
   typedef struct packed {
      logic valid;
      logic smp;     // this beat takes a sample into the ring
      logic phase;   // blink phase after this beat
   } tick_type;

endpackage

// File: rtl/averaged_hysteresis_thermostat.sv
// Channel   Dir  Beat fields (low bit first)
// req_      in   tdata: adc_sample[9:0]
// rsp_      out  tdata: heater_on, fan_on, red_led, mean_temp[7:0]
// csr_      in   write only: 0 setpoint, 1 sample_interval, 2 blink_interval
//
// One beat per cycle in, one result beat per request, in order.
// A request passes the ring read, the sum update, the reciprocal multiply, its
// correction and the output register, in that order, before its result appears.
// Synchronous reset; the ring slots are marked empty at once, no clearing pass.
// A stalled result freezes the whole pipe; req_tready drops only then.

module averaged_hysteresis_thermostat (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [aht_pkg::REQ_TDATA_W-1:0]   req_tdata,   // adc_sample
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [aht_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // heater_on, fan_on, red_led, mean_temp
   input  logic                              csr_wen,
   input  logic [aht_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [aht_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import aht_pkg::*;

   logic [SETPOINT_W-1:0] setpoint_ff, setpoint_in;
   logic [SINT_W-1:0]     sint_ff, sint_in;
   logic [BINT_W-1:0]     bint_ff, bint_in;

   logic             en;
   logic             accept;
   tick_type         tick0;
   tick_type         tick4;
   logic [AVG_W-1:0] avg4;
   logic             heater_on;
   logic             fan_on;
   logic             red_led;
   logic [AVG_W-1:0] mean_temp;

   always_comb begin
      setpoint_in = setpoint_ff;
      sint_in     = sint_ff;
      bint_in     = bint_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            CSR_SETPOINT:   setpoint_in = csr_wdata[SETPOINT_W-1:0];
            CSR_SAMPLE_INT: sint_in     = csr_wdata[SINT_W-1:0];
            CSR_BLINK_INT:  bint_in     = csr_wdata[BINT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= SETPOINT_RST;
         sint_ff     <= SINT_RST;
         bint_ff     <= BINT_RST;
      end else begin
         setpoint_ff <= setpoint_in;
         sint_ff     <= sint_in;
         bint_ff     <= bint_in;
      end
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign accept     = req_tvalid && en;

   aht_sched u_sched (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .sample_interval (sint_ff),
      .blink_interval  (bint_ff),
      .tick            (tick0)
   );

   aht_avg u_avg (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .tick_in  (tick0),
      .sample   (req_tdata[SAMPLE_W-1:0]),
      .tick_out (tick4),
      .avg      (avg4)
   );

   aht_therm u_therm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .tick      (tick4),
      .avg       (avg4),
      .setpoint  (setpoint_ff),
      .rsp_valid (rsp_tvalid),
      .heater_on (heater_on),
      .fan_on    (fan_on),
      .red_led   (red_led),
      .mean_temp (mean_temp)
   );

   assign rsp_tdata = {(RSP_TDATA_W - AVG_W - 3)'(0), mean_temp, red_led, fan_on, heater_on};

endmodule

// File: rtl/aht_ram.sv
module aht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/aht_sched.sv
`include "averaged_hysteresis_thermostat_macros.svh"

module aht_sched (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [aht_pkg::SINT_W-1:0]    sample_interval,
   input  logic [aht_pkg::BINT_W-1:0]    blink_interval,
   output aht_pkg::tick_type             tick
);
   import aht_pkg::*;

   logic [SINT_W-1:0] sample_cnt_ff, sample_cnt_in;
   logic [BINT_W-1:0] blink_cnt_ff, blink_cnt_in;
   logic              phase_ff, phase_in;
   logic [SINT_W:0]   sample_inc;
   logic [BINT_W:0]   blink_inc;
   logic              sample_fire;
   logic              blink_fire;

   always_comb begin
      sample_inc  = {1'b0, sample_cnt_ff} + 1'b1;
      blink_inc   = {1'b0, blink_cnt_ff} + 1'b1;
      // >= so a zero interval fires every beat, and a lowered one fires at once
      sample_fire = sample_inc >= {1'b0, sample_interval};
      blink_fire  = blink_inc >= {1'b0, blink_interval};

      sample_cnt_in = sample_cnt_ff;
      blink_cnt_in  = blink_cnt_ff;
      phase_in      = phase_ff;
      if (accept) begin
         sample_cnt_in = sample_fire ? '0 : sample_inc[SINT_W-1:0];
         blink_cnt_in  = blink_fire ? '0 : blink_inc[BINT_W-1:0];
         phase_in      = phase_ff ^ blink_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_cnt_ff <= '0;
         blink_cnt_ff  <= '0;
         phase_ff      <= 1'b0;
      end else begin
         sample_cnt_ff <= sample_cnt_in;
         blink_cnt_ff  <= blink_cnt_in;
         phase_ff      <= phase_in;
      end
   end

   assign tick.valid = accept;
   assign tick.smp   = sample_fire;
   assign tick.phase = phase_ff ^ blink_fire;

   `AHT_ASSERT_NEXT(a_phase_only_on_beat, !accept, $stable(phase_ff),
                    "blink phase moved without a beat")

endmodule

// File: rtl/aht_avg.sv
`include "averaged_hysteresis_thermostat_macros.svh"

module aht_avg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  aht_pkg::tick_type             tick_in,
   input  logic [aht_pkg::SAMPLE_W-1:0]  sample,
   output aht_pkg::tick_type             tick_out,
   output logic [aht_pkg::AVG_W-1:0]     avg
);
   import aht_pkg::*;

   // S1: ring read in flight
   tick_type            t1_ff;
   logic [SAMPLE_W-1:0] data1_ff;
   logic [IDX_W-1:0]    ptr1_ff;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   // S2: running sum updated
   tick_type            t2_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [WINDOW-1:0]   ring_vld_ff, ring_vld_in;
   // S3: dividend and quotient estimate
   tick_type            t3_ff;
   logic [X_W-1:0]      x3_ff, x3_in;
   logic [Q_W-1:0]      qe3_ff, qe3_in;
   // S4: averaged value
   tick_type            t4_ff;
   logic [AVG_W-1:0]    avg_ff, avg_in;

   logic [SAMPLE_W-1:0] ring_rdata;
   logic [SAMPLE_W-1:0] old_sample;
   logic                ring_wen;
   logic [PROD_W-1:0]   prod;
   logic [X_W-1:0]      qd;
   logic [X_W-1:0]      rem;
   logic [Q_W-1:0]      quot;

   assign ring_wen = en && t1_ff.valid && t1_ff.smp;

   // the slot being replaced is read on the accept beat; the write lands while that
   // beat sits in S1, at the previous slot, so the two never meet on one entry
   aht_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wen),
      .wr_addr (ptr1_ff),
      .wr_data (data1_ff),
      .rd_en   (en),
      .rd_addr (idx_ff),
      .rd_data (ring_rdata)
   );

   always_comb begin
      idx_in = idx_ff;
      if (en && tick_in.valid && tick_in.smp) begin
         idx_in = (idx_ff == IDX_W'(WINDOW - 1)) ? '0 : idx_ff + 1'b1;
      end

      // never-written slots read as zero
      old_sample  = ring_vld_ff[ptr1_ff] ? ring_rdata : '0;
      sum_in      = sum_ff;
      ring_vld_in = ring_vld_ff;
      if (ring_wen) begin
         sum_in               = (sum_ff - SUM_W'(old_sample)) + SUM_W'(data1_ff);
         ring_vld_in[ptr1_ff] = 1'b1;
      end

      x3_in  = X_W'(X_W'(sum_ff) * X_W'(SCALE));
      prod   = PROD_W'(sum_ff) * PROD_W'(QM);
      qe3_in = Q_W'(prod >> RECIP_SH);

      // estimate is low by at most one
      qd   = X_W'(qe3_ff) * X_W'(DIVISOR);
      rem  = x3_ff - qd;
      quot = qe3_ff + Q_W'(rem >= X_W'(DIVISOR));
      avg_in = avg_ff;
      if (t3_ff.valid && t3_ff.smp) begin
         avg_in = (quot > Q_W'(AVG_MAX)) ? AVG_W'(AVG_MAX) : quot[AVG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff       <= '0;
         t2_ff       <= '0;
         t3_ff       <= '0;
         t4_ff       <= '0;
         idx_ff      <= '0;
         sum_ff      <= '0;
         ring_vld_ff <= '0;
         avg_ff      <= '0;
      end else if (en) begin
         t1_ff       <= tick_in;
         t2_ff       <= t1_ff;
         t3_ff       <= t2_ff;
         t4_ff       <= t3_ff;
         idx_ff      <= idx_in;
         sum_ff      <= sum_in;
         ring_vld_ff <= ring_vld_in;
         avg_ff      <= avg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data1_ff <= sample;
         ptr1_ff  <= idx_ff;
         x3_ff    <= x3_in;
         qe3_ff   <= qe3_in;
      end
   end

   assign tick_out = t4_ff;
   assign avg      = avg_ff;

   `AHT_ASSERT_ALWAYS(a_sum_range, sum_ff <= SUM_W'(SUM_MAX),
                      "running sum above window maximum")
   `AHT_ASSERT_IMPLY(a_no_ring_collision, ring_wen, ptr1_ff != idx_ff,
                     "ring write and read hit one slot")
   `AHT_ASSERT_IMPLY(a_quot_correction, t3_ff.valid && t3_ff.smp,
                     rem < X_W'(2 * DIVISOR),
                     "quotient estimate off by more than one")

endmodule

// File: rtl/aht_therm.sv
`include "averaged_hysteresis_thermostat_macros.svh"

module aht_therm (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  aht_pkg::tick_type               tick,
   input  logic [aht_pkg::AVG_W-1:0]       avg,
   input  logic [aht_pkg::SETPOINT_W-1:0]  setpoint,
   output logic                            rsp_valid,
   output logic                            heater_on,
   output logic                            fan_on,
   output logic                            red_led,
   output logic [aht_pkg::AVG_W-1:0]       mean_temp
);
   import aht_pkg::*;

   logic             valid_ff, valid_in;
   logic             heat_ff, heat_in;
   logic             heater_ff, heater_in;
   logic             fan_ff, fan_in;
   logic             led_ff, led_in;
   logic [AVG_W-1:0] avg_out_ff;
   logic [AVG_W:0]   temp;
   logic [AVG_W:0]   sp;
   logic             below_band;
   logic             under_stop;
   logic             over_fan;

   always_comb begin
      temp = {1'b0, avg};
      sp   = (AVG_W + 1)'(setpoint);
      // t <= s-5 rewritten as t+5 <= s so small setpoints never start heating
      below_band = (temp + (AVG_W + 1)'(HEAT_ON_MARGIN)) <= sp;
      under_stop = temp < (sp + (AVG_W + 1)'(HEAT_OFF_MARGIN));
      over_fan   = temp >= (sp + (AVG_W + 1)'(FAN_MARGIN));
   end

   always_comb begin
      valid_in  = tick.valid;
      heat_in   = heat_ff;
      heater_in = heater_ff;
      fan_in    = fan_ff;
      led_in    = led_ff;
      if (tick.valid) begin
         if (below_band || heat_ff) begin
            if (under_stop) begin
               heat_in   = 1'b1;
               heater_in = 1'b1;
               fan_in    = 1'b0;
               led_in    = ~tick.phase;
            end else begin
               heat_in   = 1'b0;
               heater_in = 1'b0;
               led_in    = 1'b0;
            end
         end
         if (over_fan) begin
            led_in    = 1'b1;
            heater_in = 1'b0;
            fan_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         heat_ff   <= 1'b0;
         heater_ff <= 1'b0;
         fan_ff    <= 1'b0;
         led_ff    <= 1'b0;
      end else if (en) begin
         valid_ff  <= valid_in;
         heat_ff   <= heat_in;
         heater_ff <= heater_in;
         fan_ff    <= fan_in;
         led_ff    <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && tick.valid) begin
         avg_out_ff <= avg;
      end
   end

   assign rsp_valid = valid_ff;
   assign heater_on = heater_ff;
   assign fan_on    = fan_ff;
   assign red_led   = led_ff;
   assign mean_temp = avg_out_ff;

   `AHT_ASSERT_ALWAYS(a_heater_fan_excl, !(heater_ff && fan_ff),
                      "heater and fan both driven")
   `AHT_ASSERT_IMPLY(a_heat_drives_heater, heat_ff, heater_ff,
                     "heating flag set with heater off")

endmodule
